/* hw/rtl/jlpq_pkg.sv */
// ============================================================================
// jlpq_pkg
// Shared constants, types and the prime logarithm table of the lattice
// pitch quantiser.
// ============================================================================
package jlpq_pkg;

  localparam int TABLE_DEPTH  = 4096;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int MAX_EXPONENT = 20;
  localparam int FRAC_BITS    = 16;
  localparam int NUM_PRIMES   = 8;
  localparam int LIM_W        = 5;
  localparam int EXP_W        = LIM_W + 1;
  localparam int ENTRY_W      = 32;
  localparam int LOG_W        = 36;
  localparam int SUM_W        = 48;
  localparam int PITCH_W      = 21;
  localparam int OCT_W        = 16;
  localparam int SEMI_W       = 10;
  localparam int TGT_W        = ENTRY_W + 2;
  localparam int CFG_IDX_W    = 4;
  localparam int SHIFT_S      = 32 - FRAC_BITS;
  localparam int PITCH_LIMIT  = 10 << FRAC_BITS;

  // Q.32 base-two logarithm by truncating repeated squaring of the mantissa.
  function automatic logic [63:0] log2_q32(input logic [31:0] p);
    logic [63:0] m;
    logic [63:0] frac;
    int          n;
    int          i;
    n = 0;
    for (i = 0; i < 31; i++) begin
      if ((p >> (i + 1)) != 32'd0) n = i + 1;
    end
    m    = ({32'd0, p} << 31) >> n;
    frac = 64'd0;
    for (i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(n) << 32) | frac;
  endfunction

  localparam logic [63:0] LOG_TAB [NUM_PRIMES] = '{
    64'h1_0000_0000, log2_q32(32'd3), log2_q32(32'd5), log2_q32(32'd7),
    log2_q32(32'd11), log2_q32(32'd13), log2_q32(32'd17), log2_q32(32'd19)
  };

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef enum logic [1:0] {G_IDLE, G_SETUP, G_FILL} gen_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BUILD, S_LOAD, S_SIFT, S_RD_L, S_RD_R, S_CMP, S_EXT, S_EXT_A0,
    S_EXT_AI
  } sort_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_GEN, T_SORT, T_SRCH, T_SRCH_CMP, T_PICK, T_PREV, T_NEXT, T_ONE,
    T_REMAP, T_RBASE, T_RIDX, T_OUT
  } top_state_t;

endpackage

/* hw/rtl/jlpq_ram.sv */
// ============================================================================
// jlpq_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module jlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/jlpq_gen.sv */
// ============================================================================
// jlpq_gen
// Lattice enumerator: checks the lattice size and writes one unsorted entry
// per cycle, stepping the exponent odometer with precomputed sum deltas.
// ============================================================================
module jlpq_gen import jlpq_pkg::*; (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [NUM_PRIMES-1:0][LIM_W-1:0]   limits,
  output logic                               done,
  output logic                               ok,
  output logic [CNT_W-1:0]                   count,
  output mem_req_t                           req
);

  gen_state_t               state;
  logic [3:0]               k;
  logic [LIM_W-1:0]         lim   [NUM_PRIMES];
  logic signed [EXP_W-1:0]  e     [NUM_PRIMES];
  logic signed [SUM_W-1:0]  delta [NUM_PRIMES];
  logic [CNT_W-1:0]         prod;
  logic                     big;
  logic signed [SUM_W-1:0]  span_q;
  logic signed [SUM_W-1:0]  prefix;
  logic signed [SUM_W-1:0]  total;
  logic [CNT_W-1:0]         j;

  logic [2:0]               kidx;
  logic [CNT_W+EXP_W-1:0]   prodm;
  logic [LIM_W+LOG_W:0]     span_raw;
  logic signed [SUM_W-1:0]  prefix_sum;
  logic signed [SUM_W-1:0]  rsh;
  logic [ENTRY_W-1:0]       entry;
  logic                     found;
  logic [2:0]               inc_k;

  assign kidx       = k[2:0];
  assign prodm      = prod * {lim[kidx], 1'b1};
  assign span_raw   = {lim[kidx], 1'b0} * LOG_TAB[kidx][LOG_W-1:0];
  assign prefix_sum = prefix + span_q;
  assign rsh        = (total + SUM_W'(1 << (SHIFT_S - 1))) >>> SHIFT_S;

  always_comb begin
    if (rsh > SUM_W'(signed'(32'h7FFF_FFFF))) entry = 32'h7FFF_FFFF;
    else if (rsh < -SUM_W'(signed'(64'h8000_0000))) entry = 32'h8000_0000;
    else entry = rsh[ENTRY_W-1:0];
  end

  // Lowest digit that can still count up.
  always_comb begin
    found = 1'b0;
    inc_k = 3'd0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (!found && (e[i] < $signed({1'b0, lim[i]}))) begin
        found = 1'b1;
        inc_k = 3'(i);
      end
    end
  end

  always_comb begin
    req.we    = (state == G_FILL);
    req.waddr = j[ADDR_W-1:0];
    req.wdata = entry;
    req.raddr = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      ok    <= 1'b0;
      count <= CNT_W'(1);
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) begin
            for (int i = 0; i < NUM_PRIMES; i++) begin
              lim[i] <= (limits[i] > LIM_W'(MAX_EXPONENT)) ? LIM_W'(MAX_EXPONENT)
                                                           : limits[i];
            end
            k      <= 4'd0;
            prod   <= CNT_W'(1);
            big    <= 1'b0;
            span_q <= '0;
            prefix <= '0;
            state  <= G_SETUP;
          end
        end
        G_SETUP: begin
          if (k < 4'(NUM_PRIMES)) begin
            if (prodm > (CNT_W + EXP_W)'(TABLE_DEPTH)) big <= 1'b1;
            else prod <= prodm[CNT_W-1:0];
            span_q      <= SUM_W'(span_raw);
            delta[kidx] <= SUM_W'(LOG_TAB[kidx][LOG_W-1:0]) - prefix_sum;
            prefix      <= prefix_sum;
            k           <= k + 4'd1;
          end else begin
            total <= -(prefix_sum >>> 1);
            if (big) begin
              done  <= 1'b1;
              ok    <= 1'b0;
              state <= G_IDLE;
            end else begin
              for (int i = 0; i < NUM_PRIMES; i++) e[i] <= -$signed({1'b0, lim[i]});
              j     <= '0;
              count <= prod;
              state <= G_FILL;
            end
          end
        end
        G_FILL: begin
          if (j == count - CNT_W'(1)) begin
            done  <= 1'b1;
            ok    <= 1'b1;
            state <= G_IDLE;
          end else begin
            j <= j + CNT_W'(1);
            for (int i = 0; i < NUM_PRIMES; i++) begin
              if (3'(i) < inc_k) e[i] <= -$signed({1'b0, lim[i]});
              else if (3'(i) == inc_k) e[i] <= e[i] + EXP_W'(1);
            end
            total <= total + delta[inc_k];
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/jlpq_sort.sv */
// ============================================================================
// jlpq_sort
// In-place heap sort over the table memory, sifting with a held value.
// ============================================================================
module jlpq_sort import jlpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   n,
  input  logic [ENTRY_W-1:0] rdata,
  output logic               done,
  output mem_req_t           req
);

  sort_state_t state, state_next;
  logic                      ext;
  logic [CNT_W-1:0]          n_q;
  logic [CNT_W-1:0]          i;
  logic [CNT_W-1:0]          size;
  logic [ADDR_W-1:0]         root;
  logic [ADDR_W-1:0]         best;
  logic signed [ENTRY_W-1:0] v;
  logic signed [ENTRY_W-1:0] lval;
  logic signed [ENTRY_W-1:0] bval;
  logic [CNT_W-1:0]          child;
  logic [CNT_W:0]            child1;

  assign child  = {root, 1'b1};
  assign child1 = {1'b0, child} + (CNT_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    req.we     = 1'b0;
    req.waddr  = root;
    req.wdata  = v;
    req.raddr  = '0;
    unique case (state)
      S_IDLE: if (start) state_next = S_BUILD;
      S_BUILD: begin
        if (i == '0) begin
          state_next = S_EXT;
        end else begin
          req.raddr  = ADDR_W'(i - CNT_W'(1));
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_SIFT;
      S_SIFT: begin
        if (child < size) begin
          req.raddr  = child[ADDR_W-1:0];
          state_next = S_RD_L;
        end else begin
          req.we     = 1'b1;
          state_next = ext ? S_EXT : S_BUILD;
        end
      end
      S_RD_L: begin
        if (child1 < {1'b0, size}) begin
          req.raddr  = child1[ADDR_W-1:0];
          state_next = S_RD_R;
        end else begin
          state_next = S_CMP;
        end
      end
      S_RD_R: state_next = S_CMP;
      S_CMP: begin
        req.we = 1'b1;
        if (v >= bval) begin
          state_next = ext ? S_EXT : S_BUILD;
        end else begin
          req.wdata  = bval;
          state_next = S_SIFT;
        end
      end
      S_EXT: begin
        if (i == '0) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_EXT_A0;
        end
      end
      S_EXT_A0: begin
        req.raddr  = i[ADDR_W-1:0];
        state_next = S_EXT_AI;
      end
      S_EXT_AI: begin
        req.we     = 1'b1;
        req.waddr  = i[ADDR_W-1:0];
        req.wdata  = lval;
        state_next = S_SIFT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          n_q <= n;
          i   <= n >> 1;
          ext <= 1'b0;
        end
      end
      S_BUILD: begin
        if (i == '0) begin
          i   <= n_q - CNT_W'(1);
          ext <= 1'b1;
        end else begin
          root <= ADDR_W'(i - CNT_W'(1));
          size <= n_q;
          i    <= i - CNT_W'(1);
        end
      end
      S_LOAD: v <= rdata;
      S_RD_L: begin
        lval <= rdata;
        best <= child[ADDR_W-1:0];
        bval <= rdata;
      end
      S_RD_R: begin
        if ($signed(rdata) > lval) begin
          best <= child1[ADDR_W-1:0];
          bval <= rdata;
        end
      end
      S_CMP: if (!(v >= bval)) root <= best;
      S_EXT_A0: lval <= rdata;
      S_EXT_AI: begin
        v    <= rdata;
        root <= '0;
        size <= i;
        i    <= i - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/just_lattice_pitch_quantizer.sv */
// ============================================================================
// just_lattice_pitch_quantizer
// Snaps pitch voltages onto a sorted just-intonation lattice held in memory.
// ============================================================================
// Sample flow: free mode runs a binary search (one memory read and one compare
// per step), then reads the entries either side; remap mode reads the base
// entry first when the first channel sets the base, then the indexed entry.
// Rebuild: set-up over the primes, one entry per cycle to fill, a heap sort,
// then a search for the entry nearest zero.
// One item is in flight at a time; the next is taken once the result is out.
// Synchronous reset restores a one-entry table holding zero; no clearing pass.
// ============================================================================
module just_lattice_pitch_quantizer import jlpq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [20:0] pitch_in, zero fill
  input  logic [2:0]           s_tuser,   // [0] cmd, [1] first_channel, [2] remap
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [20:0] pitch_out, [36:21] octave_fraction
  output logic                 m_tuser,   // [0] overfill
  // Limit register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IDXS_W = CNT_W + 2;

  top_state_t state, state_next;

  // Configuration and persistent state.
  logic [NUM_PRIMES-1:0][LIM_W-1:0] limits;
  logic [CNT_W-1:0]           table_count;
  logic [ADDR_W-1:0]          zero_position;
  logic signed [ENTRY_W-1:0]  base_pitch;
  logic [ADDR_W-1:0]          base_position;
  logic                       overfill_flag;
  logic                       filled;

  // Per-item working registers.
  logic                       first_q;
  logic                       rb;
  logic                       zmode;
  logic signed [SEMI_W-1:0]   semis;
  logic signed [TGT_W-1:0]    target;
  logic [CNT_W-1:0]           lo;
  logic [CNT_W-1:0]           hi;
  logic [ADDR_W-1:0]          mid;
  logic [CNT_W-1:0]           j;
  logic signed [ENTRY_W-1:0]  prev;
  logic signed [ENTRY_W-1:0]  h;

  // Memory and its clients.
  mem_req_t                   gen_req, sort_req, top_req, mreq;
  logic [ENTRY_W-1:0]         ram_rdata;
  logic signed [ENTRY_W-1:0]  rd;
  logic                       gen_start, gen_done, gen_ok;
  logic [CNT_W-1:0]           gen_count;
  logic                       sort_start, sort_done;

  logic                       accept;
  logic signed [PITCH_W-1:0]  pitch_in;
  logic signed [ENTRY_W-1:0]  base_eff;
  logic signed [PITCH_W+3:0]  x12;
  logic [PITCH_W+3:0]         mag;
  logic [PITCH_W+3:0]         mag_r;
  logic signed [IDXS_W-1:0]   idx_a, idx_b;
  logic [ADDR_W-1:0]          idx_a_c, idx_b_c;
  logic [CNT_W-1:0]           mid_c;
  logic signed [TGT_W:0]      d_prev, d_next;
  logic signed [ENTRY_W:0]    pitch_sum;
  logic [PITCH_W-1:0]         pitch_out;

  function automatic logic [ADDR_W-1:0] clamp_idx(input logic signed [IDXS_W-1:0] val,
                                                  input logic [CNT_W-1:0] cnt);
    logic signed [IDXS_W-1:0] last;
    last = $signed({2'b00, cnt}) - IDXS_W'(1);
    if (val < 0) return '0;
    if (val > last) return last[ADDR_W-1:0];
    return val[ADDR_W-1:0];
  endfunction

  function automatic logic signed [TGT_W:0] abs_t(input logic signed [TGT_W:0] val);
    return (val < 0) ? -val : val;
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pitch_in  = $signed(s_tdata[PITCH_W-1:0]);

  // Entry zero reads as zero until the first rebuild has filled the table.
  assign rd = filled ? $signed(ram_rdata) : '0;

  jlpq_gen u_gen (
    .clk    (clk),
    .rst    (rst),
    .start  (gen_start),
    .limits (limits),
    .done   (gen_done),
    .ok     (gen_ok),
    .count  (gen_count),
    .req    (gen_req)
  );

  jlpq_sort u_sort (
    .clk   (clk),
    .rst   (rst),
    .start (sort_start),
    .n     (gen_count),
    .rdata (ram_rdata),
    .done  (sort_done),
    .req   (sort_req)
  );

  always_comb begin
    if (state == T_GEN) mreq = gen_req;
    else if (state == T_SORT) mreq = sort_req;
    else mreq = top_req;
  end

  jlpq_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (ram_rdata)
  );

  // Remap: twelve semitones per volt, rounded half away from zero.
  assign x12   = ($signed({{3{pitch_in[PITCH_W-1]}}, pitch_in}) <<< 3)
               + ($signed({{3{pitch_in[PITCH_W-1]}}, pitch_in}) <<< 2);
  assign mag   = x12[PITCH_W+3] ? (PITCH_W+4)'(-x12) : x12;
  assign mag_r = (mag + (PITCH_W+4)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  assign base_eff = s_tuser[1] ? ENTRY_W'(pitch_in) : base_pitch;
  assign idx_a    = IDXS_W'(semis) + $signed({3'b000, zero_position});
  assign idx_b    = idx_a - $signed({3'b000, base_position});
  assign idx_a_c  = clamp_idx(idx_a, table_count);
  assign idx_b_c  = clamp_idx(idx_b, table_count);
  assign mid_c    = lo + ((hi - lo) >> 1);
  assign d_prev   = abs_t((TGT_W+1)'(prev) - (TGT_W+1)'(target));
  assign d_next   = abs_t((TGT_W+1)'(rd) - (TGT_W+1)'(target));

  // Control sequence and memory read addresses.
  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    gen_start     = 1'b0;
    sort_start    = 1'b0;
    top_req.we    = 1'b0;
    top_req.waddr = '0;
    top_req.wdata = '0;
    top_req.raddr = '0;
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          if (s_tuser[0]) begin
            gen_start  = 1'b1;
            state_next = T_GEN;
          end else if (s_tuser[2]) begin
            state_next = T_REMAP;
          end else begin
            state_next = T_SRCH;
          end
        end
      end
      T_GEN: begin
        if (gen_done) begin
          if (gen_ok) begin
            sort_start = 1'b1;
            state_next = T_SORT;
          end else begin
            state_next = T_OUT;
          end
        end
      end
      T_SORT: if (sort_done) state_next = T_SRCH;
      T_SRCH: begin
        if (lo < hi) begin
          top_req.raddr = mid_c[ADDR_W-1:0];
          state_next    = T_SRCH_CMP;
        end else begin
          state_next = T_PICK;
        end
      end
      T_SRCH_CMP: state_next = T_SRCH;
      T_PICK: begin
        if (j >= table_count) begin
          top_req.raddr = ADDR_W'(table_count - CNT_W'(1));
          state_next    = T_ONE;
        end else if (j == '0) begin
          state_next = T_ONE;
        end else begin
          top_req.raddr = ADDR_W'(j - CNT_W'(1));
          state_next    = T_PREV;
        end
      end
      T_PREV: begin
        top_req.raddr = j[ADDR_W-1:0];
        state_next    = T_NEXT;
      end
      T_NEXT: state_next = T_OUT;
      T_ONE: state_next = T_OUT;
      T_REMAP: begin
        if (first_q) begin
          top_req.raddr = idx_a_c;
          state_next    = T_RBASE;
        end else begin
          state_next = T_RIDX;
        end
      end
      T_RBASE: state_next = T_RIDX;
      T_RIDX: begin
        top_req.raddr = idx_b_c;
        state_next    = T_ONE;
      end
      T_OUT: if (!m_tvalid || m_tready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_PRIMES))) begin
      limits[cfg_index[2:0]] <= cfg_data[LIM_W-1:0];
    end
  end

  // Table bookkeeping, base tracking and search registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_count   <= CNT_W'(1);
      zero_position <= '0;
      base_pitch    <= '0;
      base_position <= '0;
      overfill_flag <= 1'b0;
      filled        <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            first_q <= s_tuser[1];
            rb      <= s_tuser[0];
            zmode   <= 1'b0;
            lo      <= '0;
            hi      <= table_count;
            semis   <= x12[PITCH_W+3] ? -SEMI_W'(mag_r) : SEMI_W'(mag_r);
            target  <= TGT_W'(pitch_in) - TGT_W'(base_eff);
            if (!s_tuser[0] && !s_tuser[2] && s_tuser[1]) base_pitch <= base_eff;
          end
        end
        T_GEN: begin
          if (gen_done) begin
            overfill_flag <= !gen_ok;
            if (gen_ok) begin
              table_count <= gen_count;
              filled      <= 1'b1;
            end
          end
        end
        T_SORT: begin
          if (sort_done) begin
            zmode  <= 1'b1;
            target <= '0;
            lo     <= '0;
            hi     <= table_count;
          end
        end
        T_SRCH: begin
          mid <= mid_c[ADDR_W-1:0];
          if (!(lo < hi)) j <= lo;
        end
        T_SRCH_CMP: begin
          if ((TGT_W'(rd)) < target) lo <= {1'b0, mid} + CNT_W'(1);
          else hi <= {1'b0, mid};
        end
        T_PREV: prev <= rd;
        T_NEXT: begin
          // Nearest zero keeps the lower entry on a tie; samples keep the upper.
          if (zmode) begin
            zero_position <= (abs_t((TGT_W+1)'(rd)) < abs_t((TGT_W+1)'(prev)))
                           ? j[ADDR_W-1:0] : ADDR_W'(j - CNT_W'(1));
          end else begin
            h <= (d_prev < d_next) ? prev : rd;
          end
        end
        T_ONE: begin
          if (zmode) begin
            zero_position <= (j >= table_count) ? ADDR_W'(table_count - CNT_W'(1))
                                                : '0;
          end else begin
            h <= rd;
          end
        end
        T_REMAP: if (first_q) base_position <= idx_a_c;
        T_RBASE: base_pitch <= rd;
        default: ;
      endcase
    end
  end

  // Result register: base plus chosen interval, clamped; zero for a rebuild.
  assign pitch_sum = (ENTRY_W+1)'(base_pitch) + (ENTRY_W+1)'(h);

  always_comb begin
    if (pitch_sum > (ENTRY_W+1)'(PITCH_LIMIT)) pitch_out = PITCH_W'(PITCH_LIMIT);
    else if (pitch_sum < -(ENTRY_W+1)'(PITCH_LIMIT)) pitch_out = PITCH_W'(-PITCH_LIMIT);
    else pitch_out = pitch_sum[PITCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == T_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= overfill_flag;
        if (rb) m_tdata <= '0;
        else m_tdata <= {3'b000, h[FRAC_BITS-1:FRAC_BITS-OCT_W], pitch_out};
      end
    end
  end

  // The table never empties or outgrows the memory.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (table_count != '0) && (table_count <= CNT_W'(TABLE_DEPTH)))
    else $error("table size out of range");

  // The entry nearest zero lies inside the table whenever no rebuild is
  // between setting the new size and finding the new zero entry.
  a_zero_inside: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE || state == T_OUT || !rb) |-> ({1'b0, zero_position} < table_count))
    else $error("zero position beyond table end");

  // The overfill flag only changes at the end of a rebuild.
  a_overfill_rebuild: assert property (@(posedge clk) disable iff (rst)
    !$stable(overfill_flag) |-> (state == T_OUT || state == T_SORT))
    else $error("overfill flag changed outside a rebuild");

endmodule
